@@ src/xcr_pkg.sv @@
// Shared constants, codes and types for the XMODEM checksum receiver.
package xcr_pkg;

  localparam int PAYLOAD_BYTES = 128;
  localparam int WORD_BYTES    = 8;
  localparam int WORD_W        = 8 * WORD_BYTES;
  localparam int PAYLOAD_WORDS = PAYLOAD_BYTES / WORD_BYTES;
  localparam int BYTE_CNT_W    = $clog2(PAYLOAD_BYTES);
  localparam int LANE_W        = $clog2(WORD_BYTES);
  localparam int WORD_IDX_W    = BYTE_CNT_W - LANE_W;
  localparam int WORD_CNT_W    = WORD_IDX_W + 1;
  localparam int ADDR_W        = 32;
  localparam int CFG_IDX_W     = 1;

  typedef logic [7:0] octet_t;

  localparam octet_t CH_SOH   = 8'h01;
  localparam octet_t CH_EOT   = 8'h04;
  localparam octet_t CH_ACK   = 8'h06;
  localparam octet_t CH_NAK   = 8'h15;
  localparam octet_t CH_ONES  = 8'hFF;
  localparam octet_t CH_NONE  = 8'h00;

  localparam logic [ADDR_W-1:0] LOAD_BASE_RST = 32'h0000_8000;
  localparam logic [31:0]       TIMEOUT_RST   = 32'd4000000;

  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'b1;

  localparam logic MODE_BYTE  = 1'b0;
  localparam logic MODE_TICK  = 1'b1;
  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_SOH,
    ST_BLK,
    ST_CMP,
    ST_DATA,
    ST_SUM,
    ST_FLUSH,
    ST_ACK,
    ST_DONE
  } rx_state_t;

endpackage

@@ src/xcr_ram.sv @@
// Generic simple dual-port RAM with a registered read port.
module xcr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold the last read word until the next read
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/xmodem_checksum_receiver.sv @@
// Top level of the XMODEM (8-bit checksum) receiver that loads an image into memory.
//
// The input channel (in_valid/in_ready) carries one request per received UART
// byte (in_mode = 0) or per timer tick (in_mode = 1). The result channel
// (out_valid/out_ready) carries reply bytes (out_kind = 0, ACK or NAK) and 64-bit
// memory writes (out_kind = 1); out_last marks the final result of a request.
// A reply appears the cycle after its request is taken, and the next request is
// taken as soon as the output register is free: one request per cycle when the
// sink keeps out_ready high.
// A good checksum starts a flush: the 16 payload words leave the RAM one per
// cycle, then the ACK follows; the single RAM read port sets this pace. No
// request is taken during the flush. When the sink stalls, the current result
// holds and the flush pauses with it; nothing is dropped.
// Synchronous reset (rst_n low) returns to awaiting SOH with block number 1,
// write address 0x8000 and timeout 4000000 ticks. The payload RAM needs no
// clearing: every word is written within a packet before it is read.
// After the EOT is answered (ACK with out_start_image), requests are taken and
// dropped. Write configuration (cfg_we/cfg_index/cfg_wdata) only while idle;
// writing load_base also reloads the write address.
module xmodem_checksum_receiver (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [xcr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_mode,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_kind,
  output logic [7:0]                     out_reply_byte,
  output logic [xcr_pkg::ADDR_W-1:0]     out_write_addr,
  output logic [xcr_pkg::WORD_W-1:0]     out_write_data,
  output logic                           out_start_image,
  output logic                           out_last
);

  import xcr_pkg::*;

  // control state
  rx_state_t              state_r, state_nxt;
  logic [BYTE_CNT_W-1:0]  byte_cnt_r, byte_cnt_nxt;
  logic [WORD_CNT_W-1:0]  rd_cnt_r, rd_cnt_nxt;
  logic [WORD_IDX_W-1:0]  emit_cnt_r, emit_cnt_nxt;
  logic                   rd_pend_r, rd_pend_nxt;
  logic [31:0]            idle_count_r, idle_count_nxt;
  octet_t                 expected_block_r, expected_block_nxt;

  // configuration
  logic [31:0]            timeout_r, timeout_nxt;
  logic [ADDR_W-1:0]      next_write_addr_r, next_write_addr_nxt;

  // packet datapath
  octet_t                 block_seen_r, block_seen_nxt;
  octet_t                 running_sum_r, running_sum_nxt;
  logic [WORD_W-1:0]      word_r, word_nxt;
  logic [ADDR_W-1:0]      flush_addr_r, flush_addr_nxt;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_kind_r, out_kind_nxt;
  octet_t                 out_reply_r, out_reply_nxt;
  logic [ADDR_W-1:0]      out_addr_r, out_addr_nxt;
  logic [WORD_W-1:0]      out_data_r, out_data_nxt;
  logic                   out_start_r, out_start_nxt;
  logic                   out_last_r, out_last_nxt;

  // decode
  logic                   out_free;
  logic                   rx_state;
  logic                   in_fire;
  logic                   is_byte;
  logic                   is_tick;
  logic [32:0]            tick_cnt;
  logic                   tick_nak;
  logic                   blk_ok;
  logic                   cmp_ok;
  logic                   sum_ok;
  logic                   data_last;
  logic                   ld_word;
  logic                   rd_issue;
  logic                   last_word;

  // reply request
  logic                   ld_reply;
  octet_t                 reply_code;
  logic                   reply_start;

  // payload RAM
  logic                   ram_we;
  logic [WORD_W-1:0]      ram_wdata;
  logic [WORD_W-1:0]      ram_rdata;

  xcr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (PAYLOAD_WORDS)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (byte_cnt_r[BYTE_CNT_W-1:LANE_W]),
    .wdata (ram_wdata),
    .re    (rd_issue),
    .raddr (rd_cnt_r[WORD_IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // In the receive states, take a request whenever a single reply would find the output register free;
  // after the transfer ends, take and drop everything.
  assign out_free = !out_valid_r || out_ready;
  assign rx_state = (state_r == ST_SOH) || (state_r == ST_BLK) || (state_r == ST_CMP) ||
                    (state_r == ST_DATA) || (state_r == ST_SUM);
  assign in_ready = (state_r == ST_DONE) || (rx_state && out_free);
  assign in_fire  = in_valid && in_ready;
  assign is_byte  = in_fire && rx_state && (in_mode == MODE_BYTE);
  assign is_tick  = in_fire && rx_state && (in_mode == MODE_TICK);

  // idle timer: the count is compared one wider so a full count cannot wrap
  assign tick_cnt = {1'b0, idle_count_r} + 33'd1;
  assign tick_nak = tick_cnt >= {1'b0, timeout_r};

  assign blk_ok    = in_rx_byte == expected_block_r;
  assign cmp_ok    = in_rx_byte == (CH_ONES - block_seen_r);
  assign sum_ok    = in_rx_byte == running_sum_r;
  assign data_last = byte_cnt_r == BYTE_CNT_W'(PAYLOAD_BYTES - 1);

  // Flush: keep one word in the RAM read register ahead of the output register.
  // A read is issued when the read register is empty or is drained this cycle.
  assign ld_word   = (state_r == ST_FLUSH) && rd_pend_r && out_free;
  assign rd_issue  = (state_r == ST_FLUSH) && (rd_cnt_r < WORD_CNT_W'(PAYLOAD_WORDS)) &&
                     (!rd_pend_r || out_free);
  assign last_word = emit_cnt_r == WORD_IDX_W'(PAYLOAD_WORDS - 1);

  // assemble payload bytes into a word, first byte ending up in the low bits
  assign ram_wdata = {in_rx_byte, word_r[WORD_W-1:8]};
  assign ram_we    = is_byte && (state_r == ST_DATA) &&
                     (byte_cnt_r[LANE_W-1:0] == LANE_W'(WORD_BYTES - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_SOH: begin
        if (is_byte) begin
          if (in_rx_byte == CH_EOT) begin
            state_nxt = ST_DONE;
          end else if (in_rx_byte == CH_SOH) begin
            state_nxt = ST_BLK;
          end
        end
      end
      ST_BLK: begin
        if (is_byte) begin
          state_nxt = blk_ok ? ST_CMP : ST_SOH;
        end
      end
      ST_CMP: begin
        if (is_byte) begin
          state_nxt = cmp_ok ? ST_DATA : ST_SOH;
        end
      end
      ST_DATA: begin
        if (is_byte && data_last) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (is_byte) begin
          state_nxt = sum_ok ? ST_FLUSH : ST_SOH;
        end
      end
      ST_FLUSH: begin
        if (ld_word && last_word) begin
          state_nxt = ST_ACK;
        end
      end
      ST_ACK: begin
        if (out_free) begin
          state_nxt = ST_SOH;
        end
      end
      ST_DONE: begin
        state_nxt = ST_DONE;
      end
      default: begin
        state_nxt = ST_SOH;
      end
    endcase
  end

  // datapath and result register
  always_comb begin
    byte_cnt_nxt        = byte_cnt_r;
    rd_cnt_nxt          = rd_cnt_r;
    emit_cnt_nxt        = emit_cnt_r;
    rd_pend_nxt         = rd_pend_r;
    idle_count_nxt      = idle_count_r;
    expected_block_nxt  = expected_block_r;
    timeout_nxt         = timeout_r;
    next_write_addr_nxt = next_write_addr_r;
    block_seen_nxt      = block_seen_r;
    running_sum_nxt     = running_sum_r;
    word_nxt            = word_r;
    flush_addr_nxt      = flush_addr_r;
    ld_reply            = 1'b0;
    reply_code          = CH_NAK;
    reply_start         = 1'b0;

    if (is_tick) begin
      if (tick_nak) begin
        idle_count_nxt = '0;
        ld_reply       = 1'b1;
      end else begin
        idle_count_nxt = tick_cnt[31:0];
      end
    end

    if (is_byte) begin
      idle_count_nxt = '0;
    end

    unique case (state_r)
      ST_SOH: begin
        if (is_byte) begin
          if (in_rx_byte == CH_EOT) begin
            ld_reply    = 1'b1;
            reply_code  = CH_ACK;
            reply_start = 1'b1;
          end else if (in_rx_byte == CH_SOH) begin
            running_sum_nxt = in_rx_byte;
          end else begin
            ld_reply = 1'b1;
          end
        end
      end
      ST_BLK: begin
        if (is_byte) begin
          if (blk_ok) begin
            block_seen_nxt  = in_rx_byte;
            running_sum_nxt = running_sum_r + in_rx_byte;
          end else begin
            ld_reply = 1'b1;
          end
        end
      end
      ST_CMP: begin
        if (is_byte) begin
          if (cmp_ok) begin
            running_sum_nxt = running_sum_r + in_rx_byte;
            byte_cnt_nxt    = '0;
          end else begin
            ld_reply = 1'b1;
          end
        end
      end
      ST_DATA: begin
        if (is_byte) begin
          running_sum_nxt = running_sum_r + in_rx_byte;
          word_nxt        = ram_wdata;
          byte_cnt_nxt    = byte_cnt_r + BYTE_CNT_W'(1);
        end
      end
      ST_SUM: begin
        if (is_byte) begin
          if (sum_ok) begin
            rd_cnt_nxt     = '0;
            emit_cnt_nxt   = '0;
            rd_pend_nxt    = 1'b0;
            flush_addr_nxt = next_write_addr_r;
          end else begin
            ld_reply = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (rd_issue) begin
          rd_cnt_nxt  = rd_cnt_r + WORD_CNT_W'(1);
          rd_pend_nxt = 1'b1;
        end else if (ld_word) begin
          rd_pend_nxt = 1'b0;
        end
        if (ld_word) begin
          emit_cnt_nxt   = emit_cnt_r + WORD_IDX_W'(1);
          flush_addr_nxt = flush_addr_r + ADDR_W'(WORD_BYTES);
        end
      end
      ST_ACK: begin
        if (out_free) begin
          ld_reply            = 1'b1;
          reply_code          = CH_ACK;
          next_write_addr_nxt = next_write_addr_r + ADDR_W'(PAYLOAD_BYTES);
          expected_block_nxt  = expected_block_r + 8'd1;
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase

    // the user must write configuration only while idle; the block does not enforce it
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOAD_BASE: begin
          next_write_addr_nxt = cfg_wdata;
        end
        CFG_TIMEOUT: begin
          timeout_nxt = cfg_wdata;
        end
        default: begin
        end
      endcase
    end

    // result register: load a reply or a flushed word, else drain on accept
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_reply_nxt = out_reply_r;
    out_addr_nxt  = out_addr_r;
    out_data_nxt  = out_data_r;
    out_start_nxt = out_start_r;
    out_last_nxt  = out_last_r;
    if (ld_reply) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_REPLY;
      out_reply_nxt = reply_code;
      out_addr_nxt  = '0;
      out_data_nxt  = '0;
      out_start_nxt = reply_start;
      out_last_nxt  = 1'b1;
    end else if (ld_word) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_WRITE;
      out_reply_nxt = CH_NONE;
      out_addr_nxt  = flush_addr_r;
      out_data_nxt  = ram_rdata;
      out_start_nxt = 1'b0;
      out_last_nxt  = 1'b0;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_SOH;
      rd_pend_r         <= 1'b0;
      idle_count_r      <= '0;
      expected_block_r  <= 8'd1;
      timeout_r         <= TIMEOUT_RST;
      next_write_addr_r <= LOAD_BASE_RST;
      out_valid_r       <= 1'b0;
    end else begin
      state_r           <= state_nxt;
      rd_pend_r         <= rd_pend_nxt;
      idle_count_r      <= idle_count_nxt;
      expected_block_r  <= expected_block_nxt;
      timeout_r         <= timeout_nxt;
      next_write_addr_r <= next_write_addr_nxt;
      out_valid_r       <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_cnt_r    <= byte_cnt_nxt;
    rd_cnt_r      <= rd_cnt_nxt;
    emit_cnt_r    <= emit_cnt_nxt;
    block_seen_r  <= block_seen_nxt;
    running_sum_r <= running_sum_nxt;
    word_r        <= word_nxt;
    flush_addr_r  <= flush_addr_nxt;
    out_kind_r    <= out_kind_nxt;
    out_reply_r   <= out_reply_nxt;
    out_addr_r    <= out_addr_nxt;
    out_data_r    <= out_data_nxt;
    out_start_r   <= out_start_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_reply_byte  = out_reply_r;
  assign out_write_addr  = out_addr_r;
  assign out_write_data  = out_data_r;
  assign out_start_image = out_start_r;
  assign out_last        = out_last_r;

endmodule

@@ src/xcr_checker.sv @@
// Port-level assertions for the XMODEM checksum receiver, bound to the top level.
module xcr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_kind,
  input logic [7:0]                     out_reply_byte,
  input logic [xcr_pkg::ADDR_W-1:0]     out_write_addr,
  input logic [xcr_pkg::WORD_W-1:0]     out_write_data,
  input logic                           out_start_image,
  input logic                           out_last
);

  import xcr_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_kind) && $stable(out_reply_byte) &&
      $stable(out_write_addr) && $stable(out_write_data))
    else $error("result dropped or changed while stalled");

  // the transfer-done flag rides only on a final ACK reply
  a_start_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_start_image |->
      out_kind == KIND_REPLY && out_reply_byte == CH_ACK && out_last)
    else $error("start flag outside the final ACK");

  // a memory write is never the final result of a request
  a_write_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_WRITE |->
      !out_last && !out_start_image && out_reply_byte == CH_NONE)
    else $error("malformed memory write result");

  // flushed words and the closing ACK follow without a gap
  a_flush_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind == KIND_WRITE |=> out_valid)
    else $error("gap in payload flush");

endmodule

bind xmodem_checksum_receiver xcr_checker u_xcr_checker (.*);

@@ verif/tb_xmodem_checksum_receiver.sv @@
// Self-checking testbench for the XMODEM checksum receiver: packets, timeouts, EOT.
`timescale 1ns / 1ps

module tb_xmodem_checksum_receiver;
  import xcr_pkg::*;

  localparam int PKT_LEN = PAYLOAD_BYTES + 4;
  localparam int SETTLE  = 40;

  // One result as the block presents it, most significant field first.
  typedef struct packed {
    logic              kind;
    octet_t            reply_byte;
    logic [ADDR_W-1:0] write_addr;
    logic [WORD_W-1:0] write_data;
    logic              start_image;
    logic              last;
  } xfer_result_t;

  // Tracks the receiver state, predicts results per request and checks them.
  class load_tracker;
    logic [31:0]  base_addr;
    logic [31:0]  timeout_limit;
    logic [31:0]  write_ptr;
    logic [31:0]  idle_ticks;
    int           pos;
    octet_t       next_block;
    octet_t       header_block;
    octet_t       sum;
    octet_t       image_buf [PAYLOAD_BYTES];
    bit           done;
    int           errors;
    xfer_result_t pending_results [$];

    function new();
      base_addr     = LOAD_BASE_RST;
      timeout_limit = TIMEOUT_RST;
      write_ptr     = LOAD_BASE_RST;
      idle_ticks    = '0;
      pos           = 0;
      next_block    = 8'd1;
      header_block  = CH_NONE;
      sum           = CH_NONE;
      done          = 1'b0;
      errors        = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      if (idx == CFG_LOAD_BASE) begin
        base_addr = val;
        write_ptr = val;
      end else if (idx == CFG_TIMEOUT) begin
        timeout_limit = val;
      end
    endfunction

    function bit at_packet_start();
      return pos == 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function xfer_result_t reply_res(octet_t code, logic start);
      xfer_result_t r;
      r = '0;
      r.kind        = KIND_REPLY;
      r.reply_byte  = code;
      r.start_image = start;
      return r;
    endfunction

    function void note_request(logic m, octet_t b);
      xfer_result_t batch [$];
      xfer_result_t r;
      logic [32:0]  cnt;
      if (done) return;
      if (m == MODE_TICK) begin
        cnt = {1'b0, idle_ticks} + 33'd1;
        if (cnt >= {1'b0, timeout_limit}) begin
          idle_ticks = '0;
          batch.push_back(reply_res(CH_NAK, 1'b0));
        end else begin
          idle_ticks = cnt[31:0];
        end
      end else begin
        idle_ticks = '0;
        if (pos == 0) begin
          if (b == CH_EOT) begin
            done = 1'b1;
            batch.push_back(reply_res(CH_ACK, 1'b1));
          end else if (b == CH_SOH) begin
            sum = b;
            pos = 1;
          end else begin
            batch.push_back(reply_res(CH_NAK, 1'b0));
          end
        end else if (pos == 1) begin
          if (b == next_block) begin
            header_block = b;
            sum += b;
            pos = 2;
          end else begin
            pos = 0;
            batch.push_back(reply_res(CH_NAK, 1'b0));
          end
        end else if (pos == 2) begin
          if (b == octet_t'(CH_ONES - header_block)) begin
            sum += b;
            pos = 3;
          end else begin
            pos = 0;
            batch.push_back(reply_res(CH_NAK, 1'b0));
          end
        end else if (pos < PAYLOAD_BYTES + 3) begin
          image_buf[pos - 3] = b;
          sum += b;
          pos++;
        end else begin
          if (b == sum) begin
            for (int w = 0; w < PAYLOAD_WORDS; w++) begin
              r = '0;
              r.kind       = KIND_WRITE;
              r.write_addr = write_ptr + 32'(w * WORD_BYTES);
              for (int k = 0; k < WORD_BYTES; k++)
                r.write_data[8*k +: 8] = image_buf[w * WORD_BYTES + k];
              batch.push_back(r);
            end
            write_ptr += 32'(PAYLOAD_BYTES);
            next_block++;
            batch.push_back(reply_res(CH_ACK, 1'b0));
          end else begin
            batch.push_back(reply_res(CH_NAK, 1'b0));
          end
          pos = 0;
        end
      end
      if (batch.size() > 0) begin
        r = batch.pop_back();
        r.last = 1'b1;
        batch.push_back(r);
      end
      foreach (batch[i]) pending_results.push_back(batch[i]);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 50) $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    task check_result(xfer_result_t got);
      xfer_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d reply %h addr %h data %h",
                                  got.kind, got.reply_byte, got.write_addr, got.write_data));
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.reply_byte !== want.reply_byte)
        report_mismatch($sformatf("reply_byte %h, want %h", got.reply_byte, want.reply_byte));
      if (got.write_addr !== want.write_addr)
        report_mismatch($sformatf("write_addr %h, want %h", got.write_addr, want.write_addr));
      if (got.write_data !== want.write_data)
        report_mismatch($sformatf("write_data %h, want %h", got.write_data, want.write_data));
      if (got.start_image !== want.start_image)
        report_mismatch($sformatf("start_image %0d, want %0d", got.start_image,
                                  want.start_image));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
    endtask
  endclass

  // Every input starts at a known value; reset is held from time zero.
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_LOAD_BASE;
  logic [31:0]          cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_mode = MODE_BYTE;
  octet_t               in_rx_byte = CH_NONE;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_kind;
  octet_t               out_reply_byte;
  logic [ADDR_W-1:0]    out_write_addr;
  logic [WORD_W-1:0]    out_write_data;
  logic                 out_start_image;
  logic                 out_last;

  load_tracker tracker = new();
  int          sent = 0;
  int          in_idle_pct = 0;
  int          out_idle_pct = 0;

  xmodem_checksum_receiver dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_reply_byte  (out_reply_byte),
    .out_write_addr  (out_write_addr),
    .out_write_data  (out_write_data),
    .out_start_image (out_start_image),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: stall at random on the falling edge, per the current idle ratio.
  initial begin
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // Check every result taken at a rising edge against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_result({out_kind, out_reply_byte, out_write_addr, out_write_data,
                            out_start_image, out_last});
  end

  // Present one request at a falling edge, after a random gap, and hold it
  // until it is taken; valid stays high when the next request follows at once.
  task automatic send_item(logic m, octet_t b);
    @(negedge clk);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= m;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(m, b);
    sent++;
  endtask

  // Ticks carry a random byte that the block must ignore.
  task automatic send_ticks(int n);
    repeat (n) send_item(MODE_TICK, octet_t'($urandom));
  endtask

  // Feed random bytes until the block is back at a packet boundary.
  task automatic resync();
    while (!tracker.at_packet_start()) send_item(MODE_BYTE, octet_t'($urandom));
  endtask

  // Build a packet for the expected block with random payload; optionally
  // corrupt the checksum, sprinkle tick runs and cut it short.
  task automatic send_packet(bit bad_sum, int tick_pct, int cut);
    octet_t pkt [PKT_LEN];
    octet_t total;
    resync();
    pkt[0] = CH_SOH;
    pkt[1] = tracker.next_block;
    pkt[2] = CH_ONES - tracker.next_block;
    total  = pkt[0] + pkt[1] + pkt[2];
    for (int i = 3; i < PKT_LEN - 1; i++) begin
      pkt[i] = octet_t'($urandom);
      total += pkt[i];
    end
    pkt[PKT_LEN-1] = bad_sum ? octet_t'(total + $urandom_range(1, 255)) : total;
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(0, 99) < tick_pct) send_ticks($urandom_range(1, 3));
      send_item(MODE_BYTE, pkt[i]);
    end
  endtask

  // Wrong block number (often the previous one, as a resend) or wrong complement.
  task automatic send_bad_header(bit wrong_complement);
    octet_t blk;
    resync();
    send_item(MODE_BYTE, CH_SOH);
    if (!wrong_complement) begin
      blk = $urandom_range(0, 1) ? octet_t'(tracker.next_block - 1) : octet_t'($urandom);
      if (blk == tracker.next_block) blk = blk ^ 8'h80;
      send_item(MODE_BYTE, blk);
    end else begin
      send_item(MODE_BYTE, tracker.next_block);
      blk = octet_t'($urandom);
      if (blk == octet_t'(CH_ONES - tracker.next_block)) blk = blk ^ 8'h01;
      send_item(MODE_BYTE, blk);
    end
  endtask

  // Short mix of broken headers, tick runs and stray bytes.
  task automatic run_mix(int n_items);
    int     start;
    int     pick;
    octet_t b;
    start = sent;
    while (sent - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_bad_header(1'b0);
      end else if (pick < 50) begin
        send_bad_header(1'b1);
      end else if (pick < 75) begin
        send_ticks($urandom_range(1, 6));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          // keep EOT out of packet start so the transfer does not end early
          b = octet_t'($urandom);
          if (tracker.at_packet_start() && b == CH_EOT) b = CH_NAK;
          send_item(MODE_BYTE, b);
        end
      end
    end
  endtask

  // Drop valid, wait for every predicted result, then let the block settle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.write_reg(idx, val);
  endtask

  initial begin
    // Hold reset from time zero, release it on a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Phase one: sender idles often, receiver stalls most of the time.
    in_idle_pct  = 35;
    out_idle_pct = 81;
    // Base near the top of the address space so the image wraps;
    // a timeout of 1 NAKs on every tick.
    write_reg(CFG_LOAD_BASE, 32'hFFFF_FFC0);
    write_reg(CFG_TIMEOUT, 32'd1);

    // Directed: ticks, stray bytes at packet start, bad block, bad complement.
    send_item(MODE_TICK, 8'hFF);
    send_item(MODE_TICK, CH_NONE);
    send_item(MODE_BYTE, CH_NONE);
    send_item(MODE_BYTE, 8'hFF);
    send_item(MODE_BYTE, CH_SOH);
    send_item(MODE_BYTE, CH_NONE);
    send_item(MODE_BYTE, CH_SOH);
    send_item(MODE_BYTE, tracker.next_block);
    send_item(MODE_BYTE, CH_NONE);
    // Good packet with ticks inside: each tick NAKs, the packet survives.
    send_packet(1'b0, 4, PKT_LEN);

    // Build up idle count, then lower the timeout beneath it: next tick NAKs.
    drain();
    write_reg(CFG_TIMEOUT, 32'd10);
    send_ticks(6);
    drain();
    write_reg(CFG_TIMEOUT, 32'd3);
    send_ticks(1);

    // Phase two: roles swapped, base at zero, timeout that never fires;
    // a resend of the previous block is among the bad headers.
    drain();
    in_idle_pct  = 81;
    out_idle_pct = 35;
    write_reg(CFG_LOAD_BASE, 32'h0000_0000);
    write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
    run_mix(25);

    // Phase three: no idling, random base, short timeout.
    drain();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    write_reg(CFG_LOAD_BASE, $urandom);
    write_reg(CFG_TIMEOUT, 32'd5);
    run_mix(25);

    // End of transfer, then requests the block must swallow silently.
    resync();
    send_item(MODE_BYTE, CH_EOT);
    repeat (12) send_item(1'($urandom_range(0, 1)), octet_t'($urandom));
    drain();

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tb_xmodem_checksum_receiver OK");
    end else begin
      $display("tb_xmodem_checksum_receiver NOT OK");
    end
    $finish;
  end

  // Watchdog: stops a run that lasts far beyond the slowest correct one.
  initial begin
    #4_000_000;
    $display("tb_xmodem_checksum_receiver NOT OK");
    $finish;
  end

endmodule
